>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/gdezm_pkg.sv
`timescale 1ns / 1ps

package gdezm_pkg;

    localparam int GRANULE_ROWS = 8192;
    localparam int VALUE_W      = 64;
    localparam int TALLY_W      = 14;
    // counter must hold GRANULE_ROWS itself
    localparam int CNT_W        = $clog2(GRANULE_ROWS + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [TALLY_W-1:0]        tally_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef struct packed {
        value_t value;
        logic   end_of_data;
    } row_t;

    typedef struct packed {
        value_t delta;
        logic   granule_done;
        value_t first_value;
        value_t min_value;
        value_t max_value;
        value_t last_value;
        tally_t row_tally;
    } result_t;

endpackage

>>> hdl/gdezm_row_if.sv
`timescale 1ns / 1ps

interface gdezm_row_if;
    logic              valid;
    logic              ready;
    gdezm_pkg::value_t value;
    logic              end_of_data;

    modport source (output valid, value, end_of_data, input ready);
    modport sink   (input valid, value, end_of_data, output ready);
endinterface

>>> hdl/gdezm_result_if.sv
`timescale 1ns / 1ps

interface gdezm_result_if;
    logic              valid;
    logic              ready;
    gdezm_pkg::value_t delta;
    logic              granule_done;
    gdezm_pkg::value_t first_value;
    gdezm_pkg::value_t min_value;
    gdezm_pkg::value_t max_value;
    gdezm_pkg::value_t last_value;
    gdezm_pkg::tally_t row_tally;

    modport source (
        output valid, delta, granule_done, first_value, min_value, max_value,
               last_value, row_tally,
        input  ready
    );
    modport sink (
        input  valid, delta, granule_done, first_value, min_value, max_value,
               last_value, row_tally,
        output ready
    );
endinterface

>>> hdl/gdezm_in_stage.sv
`timescale 1ns / 1ps

// Input register: holds one row until the core takes it.
module gdezm_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    gdezm_row_if.sink          row,
    input  logic               advance,
    output logic               item_valid,
    output gdezm_pkg::row_t    item
);

    logic            valid_reg;
    gdezm_pkg::row_t item_reg;

    assign row.ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (row.valid && row.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row.valid && row.ready)
        begin
            item_reg.value       <= row.value;
            item_reg.end_of_data <= row.end_of_data;
        end
    end

endmodule

>>> hdl/gdezm_core.sv
`timescale 1ns / 1ps

// Granule state and per-row arithmetic: one subtract, two signed compares.
module gdezm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  gdezm_pkg::row_t     item,
    input  logic                advance,
    output gdezm_pkg::result_t  res_next
);

    gdezm_pkg::cnt_t   rows_reg;
    gdezm_pkg::cnt_t   rows_next;
    gdezm_pkg::value_t prev_reg;
    gdezm_pkg::value_t base_reg;
    gdezm_pkg::value_t min_reg;
    gdezm_pkg::value_t max_reg;
    gdezm_pkg::value_t base_next;
    gdezm_pkg::value_t min_next;
    gdezm_pkg::value_t max_next;
    gdezm_pkg::value_t delta;
    gdezm_pkg::cnt_t   count;
    logic              first;
    logic              done;

    always_comb
    begin
        first = (rows_reg == '0);
        count = rows_reg + gdezm_pkg::CNT_W'(1);
        done  = item.end_of_data || (count >= gdezm_pkg::CNT_W'(gdezm_pkg::GRANULE_ROWS));

        if (first)
        begin
            delta     = '0;
            base_next = item.value;
            min_next  = item.value;
            max_next  = item.value;
        end
        else
        begin
            delta     = item.value - prev_reg;   // wraps modulo 2^64
            base_next = base_reg;
            min_next  = (item.value < min_reg) ? item.value : min_reg;
            max_next  = (max_reg < item.value) ? item.value : max_reg;
        end

        rows_next = done ? '0 : count;

        res_next.delta        = delta;
        res_next.granule_done = done;
        res_next.first_value  = base_next;
        res_next.min_value    = min_next;
        res_next.max_value    = max_next;
        res_next.last_value   = item.value;
        res_next.row_tally    = gdezm_pkg::TALLY_W'(count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else if (advance)
        begin
            rows_reg <= rows_next;
        end
    end

    // value state is only read after a first row has written it
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prev_reg <= item.value;
            base_reg <= base_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
        end
    end

endmodule

>>> hdl/gdezm_out_stage.sv
`timescale 1ns / 1ps

// Result register driving the output channel.
module gdezm_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  gdezm_pkg::result_t res_next,
    input  logic               advance,
    gdezm_result_if.source     result
);

    logic               valid_reg;
    gdezm_pkg::result_t res_reg;

    assign result.valid        = valid_reg;
    assign result.delta        = res_reg.delta;
    assign result.granule_done = res_reg.granule_done;
    assign result.first_value  = res_reg.first_value;
    assign result.min_value    = res_reg.min_value;
    assign result.max_value    = res_reg.max_value;
    assign result.last_value   = res_reg.last_value;
    assign result.row_tally    = res_reg.row_tally;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> hdl/granule_delta_encoder_with_zone_map.sv
`timescale 1ns / 1ps
// Channel   Dir  Transaction carries
// row       in   value (s64), end_of_data
// result    out  delta, granule_done, first/min/max/last_value (s64), row_tally (14b)
//
// Throughput: one row per cycle while result.ready is high; the 64-bit subtract
//   and the two signed compares in gdezm_core set the clock path.
// Path: a taken row waits in the input reg, then enters the result reg via gdezm_core.
// Reset: rst_n async, low; clears valids and the row counter (next row opens a granule).
// Stalls: result.ready low holds the result reg, then the input reg; row.ready
//   drops only when both are full and the result is not taken.

`include "assert_macros.svh"

module granule_delta_encoder_with_zone_map (
    input  logic           clk,
    input  logic           rst_n,
    gdezm_row_if.sink      row,
    gdezm_result_if.source result
);

    logic               item_valid;
    gdezm_pkg::row_t    item;
    gdezm_pkg::result_t res_next;
    logic               advance;

    // A row moves from the input reg into the result reg when the result reg
    // is empty or being emptied this cycle. Granule state updates on the same edge.
    assign advance = item_valid && (!result.valid || result.ready);

    gdezm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .row        (row),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    gdezm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .advance  (advance),
        .res_next (res_next)
    );

    gdezm_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_next (res_next),
        .advance  (advance),
        .result   (result)
    );

    // ---------------- assertions ----------------

    // First row of a granule: zero delta, summary collapses to the row value.
    `ASSERT_IMPLY(a_first_row_summary,
        result.valid && (result.row_tally == gdezm_pkg::TALLY_W'(1)),
        (result.delta == '0) && (result.first_value == result.last_value) &&
        (result.min_value == result.last_value) && (result.max_value == result.last_value),
        "first row of granule has inconsistent summary")

    // Zone map bounds enclose the last value.
    `ASSERT_IMPLY(a_last_in_bounds,
        result.valid,
        (result.min_value <= result.last_value) && (result.last_value <= result.max_value),
        "last_value outside min/max")

    // Zone map bounds enclose the first value.
    `ASSERT_IMPLY(a_base_in_bounds,
        result.valid,
        (result.min_value <= result.first_value) && (result.first_value <= result.max_value),
        "first_value outside min/max")

    // A row handed to the result reg is visible on the next cycle.
    `ASSERT_NEXT(a_advance_shows,
        advance,
        result.valid,
        "advanced row not presented on result")

endmodule

>>> tb/tb_granule_delta_encoder_with_zone_map.sv
`timescale 1ns / 1ps

module tb_granule_delta_encoder_with_zone_map;
    import gdezm_pkg::*;

    // Longest legal quiet stretch is the receiver hold-off (RX_HOLD_CYCLES) plus
    // random stalls on both sides; this leaves a wide margin.
    localparam int STALL_LIMIT = 1000;
    // Two register stages inside the block; the tail after the drain catches strays.
    localparam int TAIL_CYCLES = 10;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int RANDOM_ROWS = 560;
    localparam int NO_IDLE_ROWS = 40;

    localparam value_t MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam value_t MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n;

    gdezm_row_if    row_ch ();
    gdezm_result_if result_ch ();

    granule_delta_encoder_with_zone_map u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .row    (row_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Zone-map predictor: running state of the open granule.
    // zm_rows counts rows already in the granule; 0 means the next row
    // opens a new one.
    // ------------------------------------------------------------------
    value_t  zm_prev;
    value_t  zm_base;
    value_t  zm_min;
    value_t  zm_max;
    int      zm_rows;

    result_t expected_results[$];

    int error_count  = 0;
    int stall_cycles = 0;
    int rows_sent    = 0;

    // Idling controls. The receiver process owns rx_hold_left and counts
    // it down itself once a test loads it.
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    int rx_hold_left = 0;

    function automatic result_t encode_row(row_t r);
        result_t res;
        value_t  v;
        int      count;
        v = r.value;
        if (zm_rows == 0)
        begin
            // first row of a granule: summary restarts, delta is zero
            zm_base   = v;
            zm_min    = v;
            zm_max    = v;
            res.delta = '0;
        end
        else
        begin
            res.delta = v - zm_prev;   // wraps mod 2^64
            if (v < zm_min)
                zm_min = v;
            if (v > zm_max)
                zm_max = v;
        end
        zm_prev = v;
        count = zm_rows + 1;
        // closes on the end mark or on a full granule, never twice
        res.granule_done = r.end_of_data || (count >= GRANULE_ROWS);
        res.first_value  = zm_base;
        res.min_value    = zm_min;
        res.max_value    = zm_max;
        res.last_value   = v;
        res.row_tally    = tally_t'(count);
        zm_rows = res.granule_done ? 0 : count;
        return res;
    endfunction

    // Mix of extremes, 0 and -1, small steps from the previous value (realistic
    // timestamp-like deltas) and fully random patterns.
    function automatic value_t pick_value(value_t near);
        case ($urandom_range(7))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return $urandom_range(1) ? value_t'(-1) : value_t'(0);
            3, 4: return near + value_t'(int'($urandom_range(2000)) - 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Row side: one transaction per call. Inputs move on the falling edge,
    // acceptance is seen on the rising edge. valid stays high after the
    // transaction; the next call or wait_drained decides its next value.
    // ------------------------------------------------------------------
    task automatic send_row(input value_t value, input logic eod);
        row_t r;
        r.value       = value;
        r.end_of_data = eod;
        @(negedge clk);
        while (tx_gaps && $urandom_range(99) < 30)
        begin
            row_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_ch.valid       <= 1'b1;
        row_ch.value       <= r.value;
        row_ch.end_of_data <= r.end_of_data;
        do
            @(posedge clk);
        while (!row_ch.ready);
        expected_results.push_back(encode_row(r));
        rows_sent++;
    endtask

    // Sender goes quiet until every predicted result has come back.
    task automatic wait_drained();
        @(negedge clk);
        row_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready changes on the falling edge. A loaded hold-off
    // wins over the random stalls.
    // ------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                result_ch.ready <= !rx_gaps || ($urandom_range(99) >= 30);
            end
        end
    end

    // Each result transaction against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual delta %h",
                         $time, result_ch.delta);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("delta",        want.delta,        result_ch.delta);
                check_field("granule_done", 64'(want.granule_done),
                            64'(result_ch.granule_done));
                check_field("first_value",  want.first_value,  result_ch.first_value);
                check_field("min_value",    want.min_value,    result_ch.min_value);
                check_field("max_value",    want.max_value,    result_ch.max_value);
                check_field("last_value",   want.last_value,   result_ch.last_value);
                check_field("row_tally",    64'(want.row_tally), 64'(result_ch.row_tally));
            end
        end
    end

    // Watchdog: too long with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((row_ch.valid === 1'b1 && row_ch.ready === 1'b1)
            || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_granule_delta_encoder_with_zone_map: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Swings between the signed extremes: deltas wrap both ways, min and
    // max land on the ends of the range. Closed by the end mark.
    task automatic test_extreme_values();
        send_row(MOST_NEG, 1'b0);
        send_row(MOST_POS, 1'b0);
        send_row(MOST_NEG, 1'b0);
        send_row(value_t'(0), 1'b0);
        send_row(value_t'(-1), 1'b0);
        send_row(value_t'(1), 1'b0);
        send_row(MOST_POS, 1'b1);
    endtask

    // End mark on every row: each row is a whole granule, and rows after
    // an end mark simply open the next one.
    task automatic test_single_row_granules();
        send_row(MOST_POS, 1'b1);
        send_row(MOST_NEG, 1'b1);
        send_row(value_t'(0), 1'b1);
        send_row({$urandom, $urandom}, 1'b1);
        send_row({$urandom, $urandom}, 1'b1);
    endtask

    // Running summary on rows that do not close the granule: min and max
    // move in both directions before the end mark.
    task automatic test_running_summary();
        send_row(value_t'(1000), 1'b0);
        send_row(value_t'(1500), 1'b0);
        send_row(value_t'(-20), 1'b0);
        send_row(value_t'(900), 1'b0);
        send_row(value_t'(2000), 1'b0);
        send_row(value_t'(-21), 1'b1);
    endtask

    // Neither side idles over a long run of rows: back-to-back transactions
    // through both register stages, granules of random length.
    task automatic test_no_idle_stretch();
        value_t v;
        v = '0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        for (int i = 0; i < NO_IDLE_ROWS; i++)
        begin
            v = pick_value(v);
            send_row(v, $urandom_range(7) == 0);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Receiver holds off while rows keep coming: both stages fill and the
    // row channel must stall without losing or repeating a transaction.
    task automatic test_output_backpressure();
        value_t v;
        v = '0;
        tx_gaps = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
        begin
            v = pick_value(v);
            send_row(v, $urandom_range(9) == 0);
        end
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    // Mostly short granules closed by the end mark, some long ones, and
    // some loose rows with random end marks that leave granules open.
    task automatic test_random_stream();
        int     first;
        int     kind;
        int     len;
        value_t v;
        first = rows_sent;
        v = '0;
        while (rows_sent - first < RANDOM_ROWS)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            else if (kind < 40)
            begin
                tx_gaps = 1'b1;
                rx_gaps = 1'b1;
            end
            if (kind < 80)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(300, 64)
                                                : $urandom_range(24, 1);
                for (int i = 1; i <= len; i++)
                begin
                    v = pick_value(v);
                    send_row(v, i == len);
                end
            end
            else
            begin
                len = $urandom_range(8, 1);
                repeat (len)
                begin
                    v = pick_value(v);
                    send_row(v, $urandom_range(9) == 0);
                end
            end
            if ($urandom_range(15) == 0)
                wait_drained();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        row_ch.valid         = 1'b0;
        row_ch.value         = '0;
        row_ch.end_of_data   = 1'b0;
        zm_prev              = '0;
        zm_base              = '0;
        zm_min               = '0;
        zm_max               = '0;
        zm_rows              = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extreme_values();
        test_single_row_granules();
        test_running_summary();
        test_no_idle_stretch();
        test_output_backpressure();
        test_random_stream();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_granule_delta_encoder_with_zone_map: done, clean");
        else
            $display("tb_granule_delta_encoder_with_zone_map: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/gdezm_pkg.sv
hdl/gdezm_row_if.sv
hdl/gdezm_result_if.sv
hdl/gdezm_in_stage.sv
hdl/gdezm_core.sv
hdl/gdezm_out_stage.sv
hdl/granule_delta_encoder_with_zone_map.sv
tb/tb_granule_delta_encoder_with_zone_map.sv
